// ===== rtl/core/mt19937_64_generator_defines.svh =====
// Assertion macros shared by the generator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MT19937_64_GENERATOR_DEFINES_SVH
`define MT19937_64_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MT64_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MT64_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mt64_pkg.sv =====
// Shared constants, types and state encodings of the 64-bit twister.
// No dependencies; used by every module of the generator.
package mt64_pkg;

  localparam logic [8:0]  NumWords    = 9'd312;
  localparam logic [8:0]  LastIdx     = 9'd311;
  localparam logic [8:0]  MidOffset   = 9'd156;
  localparam int unsigned LowerBits   = 31;
  localparam logic [63:0] MatrixA     = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] TemperD     = 64'h5555_5555_5555_5555;
  localparam logic [63:0] TemperB     = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [63:0] TemperC     = 64'hFFF7_EEE0_0000_0000;
  localparam logic [63:0] SeedMult    = 64'd6364136223846793005;
  localparam logic [63:0] DefaultSeed = 64'd5489;

  typedef enum logic [2:0] {
    ST_SEED_WR0,
    ST_SEED_MUL,
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_TWIST
  } state_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LO_LO,
    PH_LO_HI,
    PH_HI_LO,
    PH_SUM
  } mul_phase_e;

  // Request to the seed recurrence unit.
  typedef struct packed {
    logic        go;
    logic [8:0]  idx;
    logic [63:0] prev;
  } seed_cmd_t;

endpackage

// ===== rtl/core/mt64_seeder.sv =====
// Seed recurrence: word[j] = F * (prev ^ (prev >> 62)) + j, mod 2^64.
// One shared 32x32 multiplier over three partial products. Uses mt64_pkg.
module mt64_seeder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mt64_pkg::seed_cmd_t  cmd_i,
  output logic                 done_o,
  output logic [63:0]          word_o
);

  mt64_pkg::mul_phase_e phase_q, phase_d;

  logic [63:0] x_q;
  logic [8:0]  idx_q;
  logic [63:0] p0_q;
  logic [31:0] p1_q;
  logic [31:0] p2_q;
  logic [63:0] word_q;
  logic        done_q;

  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;

  assign op_a = (phase_q == mt64_pkg::PH_HI_LO) ? x_q[63:32] : x_q[31:0];
  assign op_b = (phase_q == mt64_pkg::PH_LO_HI) ? mt64_pkg::SeedMult[63:32]
                                                : mt64_pkg::SeedMult[31:0];
  assign prod = 64'(op_a) * 64'(op_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mt64_pkg::PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == mt64_pkg::PH_SUM);
    end
  end

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      mt64_pkg::PH_IDLE:  if (cmd_i.go) phase_d = mt64_pkg::PH_LO_LO;
      mt64_pkg::PH_LO_LO: phase_d = mt64_pkg::PH_LO_HI;
      mt64_pkg::PH_LO_HI: phase_d = mt64_pkg::PH_HI_LO;
      mt64_pkg::PH_HI_LO: phase_d = mt64_pkg::PH_SUM;
      mt64_pkg::PH_SUM:   phase_d = mt64_pkg::PH_IDLE;
      default:            phase_d = mt64_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      mt64_pkg::PH_IDLE: begin
        if (cmd_i.go) begin
          x_q   <= cmd_i.prev ^ (cmd_i.prev >> 62);
          idx_q <= cmd_i.idx;
        end
      end
      mt64_pkg::PH_LO_LO: p0_q <= prod;
      mt64_pkg::PH_LO_HI: p1_q <= prod[31:0];
      mt64_pkg::PH_HI_LO: p2_q <= prod[31:0];
      mt64_pkg::PH_SUM:   word_q <= p0_q + {p1_q + p2_q, 32'b0} + {55'b0, idx_q};
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign word_o = word_q;

endmodule

// ===== rtl/core/mt64_twist.sv =====
// Per-word twist and output tempering with a registered result strobe.
// Uses mt64_pkg constants.
module mt64_twist (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [63:0] cur_i,
  input  logic [63:0] nxt_i,
  input  logic [63:0] far_i,
  output logic [63:0] new_word_o,
  output logic        result_valid_o,
  output logic [63:0] random_word_o
);

  localparam logic [63:0] LowerMask = (64'd1 << mt64_pkg::LowerBits) - 64'd1;

  logic [63:0] y;
  logic [63:0] z0, z1, z2, z3;
  logic        valid_q;
  logic [63:0] word_q;

  assign y          = (cur_i & ~LowerMask) | (nxt_i & LowerMask);
  assign new_word_o = far_i ^ (y >> 1) ^ (y[0] ? mt64_pkg::MatrixA : 64'd0);

  assign z0 = new_word_o ^ ((new_word_o >> 29) & mt64_pkg::TemperD);
  assign z1 = z0 ^ ((z0 << 17) & mt64_pkg::TemperB);
  assign z2 = z1 ^ ((z1 << 37) & mt64_pkg::TemperC);
  assign z3 = z2 ^ (z2 >> 43);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= z3;
    end
  end

  assign result_valid_o = valid_q;
  assign random_word_o  = word_q;

endmodule

// ===== rtl/core/mt19937_64_generator.sv =====
// Top level of the 64-bit Mersenne Twister: state store, control and checks.
// Depends on mt64_pkg, mt64_seeder, mt64_twist and the shared defines header.
//
//  channel   handshake                 payload
//  -------   ------------------------  ---------------------------
//  request   start / busy              req_type_i, seed_value_i
//  result    result_valid_o (strobe)   random_word_o
//
// A draw runs from accept through ST_RD1, ST_RD2 and ST_TWIST to the result
// strobe: the read of word i issues in the accept cycle, words i+1 and i+156
// are read in ST_RD1 and ST_RD2, then the twist-and-write in ST_TWIST, then
// the registered result. busy falls with the strobe, so the next draw can be
// accepted while the result is shown. A reseed holds busy for ST_SEED_WR0 and
// one seed recurrence per word, run through one shared 32x32 multiplier.
// Out of reset the same pass runs with seed 5489; busy stays high until done.
// The receiver cannot stall: each result is shown for one cycle only.
`include "mt19937_64_generator_defines.svh"

module mt19937_64_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [63:0] seed_value_i,
  output logic        result_valid_o,
  output logic [63:0] random_word_o
);

  // State store: 312 x 64, one write port, one registered read port.
  logic [63:0] mem_q [312];
  logic [63:0] rd_data_q;
  logic [8:0]  rd_addr;
  logic        wr_en;
  logic [8:0]  wr_addr;
  logic [63:0] wr_data;

  mt64_pkg::state_e state_q, state_d;

  logic [8:0]  pos_q, pos_d;         // read position, 312 means exhausted
  logic [8:0]  cur_idx_q, cur_idx_d; // word being drawn/twisted
  logic [8:0]  seed_idx_q, seed_idx_d;
  logic [63:0] seed_q, seed_d;
  logic [63:0] cur_q;
  logic [63:0] nxt_q;

  logic [8:0]  pos_sel;
  logic [8:0]  nxt_idx;
  logic [8:0]  far_idx;
  logic        accept;

  mt64_pkg::seed_cmd_t seed_cmd;
  logic        seed_done;
  logic [63:0] seed_word;

  logic        twist_en;
  logic [63:0] new_word;

  assign accept  = start && !busy;
  assign busy    = (state_q != mt64_pkg::ST_IDLE);

  // An exhausted position wraps to 0; words are twisted lazily in draw order,
  // which matches an in-place whole-store twist word for word.
  assign pos_sel = (pos_q >= mt64_pkg::NumWords) ? 9'd0 : pos_q;
  assign nxt_idx = (cur_idx_q == mt64_pkg::LastIdx) ? 9'd0 : cur_idx_q + 9'd1;
  assign far_idx = (cur_idx_q < mt64_pkg::MidOffset) ? cur_idx_q + mt64_pkg::MidOffset
                                                     : cur_idx_q - mt64_pkg::MidOffset;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mt64_pkg::ST_SEED_WR0;
      pos_q      <= mt64_pkg::NumWords;
      seed_q     <= mt64_pkg::DefaultSeed;
      seed_idx_q <= 9'd0;
      cur_idx_q  <= 9'd0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      seed_q     <= seed_d;
      seed_idx_q <= seed_idx_d;
      cur_idx_q  <= cur_idx_d;
    end
  end

  // Operand capture for the twist, one word per read cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == mt64_pkg::ST_RD1) begin
      cur_q <= rd_data_q;
    end
    if (state_q == mt64_pkg::ST_RD2) begin
      nxt_q <= rd_data_q;
    end
  end

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    seed_d        = seed_q;
    seed_idx_d    = seed_idx_q;
    cur_idx_d     = cur_idx_q;
    rd_addr       = pos_sel;
    wr_en         = 1'b0;
    wr_addr       = seed_idx_q;
    wr_data       = seed_word;
    twist_en      = 1'b0;
    seed_cmd.go   = 1'b0;
    seed_cmd.idx  = seed_idx_q + 9'd1;
    seed_cmd.prev = seed_word;

    unique case (state_q)
      mt64_pkg::ST_SEED_WR0: begin
        // word 0 is the seed itself; kick the recurrence for word 1
        wr_en         = 1'b1;
        wr_addr       = 9'd0;
        wr_data       = seed_q;
        seed_cmd.go   = 1'b1;
        seed_cmd.idx  = 9'd1;
        seed_cmd.prev = seed_q;
        seed_idx_d    = 9'd1;
        state_d       = mt64_pkg::ST_SEED_MUL;
      end
      mt64_pkg::ST_SEED_MUL: begin
        if (seed_done) begin
          wr_en = 1'b1;
          if (seed_idx_q == mt64_pkg::LastIdx) begin
            pos_d   = mt64_pkg::NumWords;
            state_d = mt64_pkg::ST_IDLE;
          end else begin
            seed_cmd.go = 1'b1;
            seed_idx_d  = seed_idx_q + 9'd1;
          end
        end
      end
      mt64_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_type_i) begin
            seed_d  = seed_value_i;
            state_d = mt64_pkg::ST_SEED_WR0;
          end else begin
            cur_idx_d = pos_sel;   // read of word i issued this cycle
            state_d   = mt64_pkg::ST_RD1;
          end
        end
      end
      mt64_pkg::ST_RD1: begin
        rd_addr = nxt_idx;
        state_d = mt64_pkg::ST_RD2;
      end
      mt64_pkg::ST_RD2: begin
        rd_addr = far_idx;
        state_d = mt64_pkg::ST_TWIST;
      end
      mt64_pkg::ST_TWIST: begin
        // far word arrives now; write the twisted word back in place
        twist_en = 1'b1;
        wr_en    = 1'b1;
        wr_addr  = cur_idx_q;
        wr_data  = new_word;
        pos_d    = cur_idx_q + 9'd1;
        state_d  = mt64_pkg::ST_IDLE;
      end
      default: state_d = mt64_pkg::ST_IDLE;
    endcase
  end

  mt64_seeder u_seeder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (seed_cmd),
    .done_o (seed_done),
    .word_o (seed_word)
  );

  mt64_twist u_twist (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (twist_en),
    .cur_i          (cur_q),
    .nxt_i          (nxt_q),
    .far_i          (rd_data_q),
    .new_word_o     (new_word),
    .result_valid_o (result_valid_o),
    .random_word_o  (random_word_o)
  );

  `MT64_ASSERT_NEXT(a_twist_gives_result, state_q == mt64_pkg::ST_TWIST, result_valid_o && !busy, "twist cycle did not produce a result")
  `MT64_ASSERT_NEXT(a_reseed_enters_seed, accept && req_type_i, state_q == mt64_pkg::ST_SEED_WR0 && !result_valid_o, "reseed did not start the seed pass")
  `MT64_ASSERT_NOW(a_pos_in_range, 1'b1, pos_q <= mt64_pkg::NumWords, "read position beyond the store")
  `MT64_ASSERT_NOW(a_wr_in_range, wr_en, wr_addr <= mt64_pkg::LastIdx, "store write beyond last word")
  `MT64_ASSERT_NEXT(a_seed_end_exhausted, state_q == mt64_pkg::ST_SEED_MUL && seed_done && seed_idx_q == mt64_pkg::LastIdx, pos_q == mt64_pkg::NumWords && !busy, "seed pass did not leave store exhausted")

endmodule

// ===== tb/mt19937_64_generator_tb.sv =====
// Self-checking testbench for the 64-bit Mersenne Twister generator.
// Depends on mt64_pkg and the mt19937_64_generator RTL; predicts every draw.
`timescale 1ns / 1ps

module mt19937_64_generator_tb;

  // Request codes on req_type_i
  localparam logic ReqDraw   = 1'b0;
  localparam logic ReqReseed = 1'b1;

  // Tempering shifts and the seed recurrence shift of the 64-bit twister
  localparam int unsigned TemperU = 29;
  localparam int unsigned TemperS = 17;
  localparam int unsigned TemperT = 37;
  localparam int unsigned TemperL = 43;
  localparam int unsigned SeedShift = 62;

  localparam int unsigned WordCount   = mt64_pkg::NumWords;
  localparam int unsigned FarOffset   = mt64_pkg::MidOffset;
  localparam int unsigned RandomItems = 1450;
  localparam int unsigned MaxReseeds  = 40;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned TailCycles  = 50;

  // One queued request; a drain entry makes the sender wait until every
  // expected word has come out instead of sending anything.
  typedef struct {
    logic        drain;
    logic        req;
    logic [63:0] seed;
  } gen_request_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        req_type_i   = ReqDraw;
  logic [63:0] seed_value_i = '0;
  logic        busy;
  logic        result_valid_o;
  logic [63:0] random_word_o;

  // Predictor state: the 312-word store and the read index
  logic [63:0] twister_store [WordCount];
  int unsigned read_index;

  gen_request_t requests_pending [$];
  logic [63:0]  expected_words [$];

  logic        item_taken = 1'b0;   // request accepted at the last rising edge
  logic        drain_hold = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned error_count = 0;

  mt19937_64_generator DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .seed_value_i   (seed_value_i),
    .result_valid_o (result_valid_o),
    .random_word_o  (random_word_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Multiplier recurrence: word j = f * (w[j-1] ^ (w[j-1] >> 62)) + j.
  // Leaves the index exhausted so the next draw regenerates the store.
  function automatic void fill_from_seed(input logic [63:0] seed);
    logic [63:0] prev;
    twister_store[0] = seed;
    for (int unsigned j = 1; j < WordCount; j++) begin
      prev = twister_store[j - 1];
      twister_store[j] = mt64_pkg::SeedMult * (prev ^ (prev >> SeedShift)) + 64'(j);
    end
    read_index = WordCount;
  endfunction

  // Full in-place twist of the store. Word i uses the already-updated word
  // i+156 from i = 156 on, exactly as the sequential generator does.
  function automatic void regenerate_store();
    logic [63:0] upper_mask;
    logic [63:0] mixed;
    int unsigned nxt;
    int unsigned far_idx;
    upper_mask = ~64'h0 << mt64_pkg::LowerBits;
    for (int unsigned i = 0; i < WordCount; i++) begin
      nxt     = (i + 1) % WordCount;
      far_idx = (i + FarOffset) % WordCount;
      mixed   = (twister_store[i] & upper_mask) | (twister_store[nxt] & ~upper_mask);
      twister_store[i] = twister_store[far_idx] ^ (mixed >> 1) ^
                         (mixed[0] ? mt64_pkg::MatrixA : 64'h0);
    end
    read_index = 0;
  endfunction

  function automatic logic [63:0] temper_word(input logic [63:0] raw);
    logic [63:0] z;
    z = raw;
    z ^= (z >> TemperU) & mt64_pkg::TemperD;
    z ^= (z << TemperS) & mt64_pkg::TemperB;
    z ^= (z << TemperT) & mt64_pkg::TemperC;
    z ^= z >> TemperL;
    return z;
  endfunction

  function automatic logic [63:0] next_draw_word();
    logic [63:0] word;
    if (read_index >= WordCount) begin
      regenerate_store();
    end
    word = temper_word(twister_store[read_index]);
    read_index++;
    return word;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: changes inputs on the falling edge. Holds start until busy lets
  // the item in, then works through bursts and random gaps. A drain entry
  // stalls it until the expected-word queue is empty.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic         nxt_start;
    gen_request_t req;
    nxt_start = start;
    if (!rst_ni) begin
      nxt_start = 1'b0;
    end else if (!start || item_taken) begin
      nxt_start = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (drain_hold) begin
        if (expected_words.size() == 0) drain_hold = 1'b0;
      end else if (requests_pending.size() > 0) begin
        req = requests_pending.pop_front();
        if (req.drain) begin
          drain_hold = 1'b1;
        end else begin
          req_type_i   <= req.req;
          seed_value_i <= req.seed;
          nxt_start    = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // roughly a quarter of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
    start <= nxt_start;
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples on the rising edge. Checks a strobed word against the
  // oldest expectation first, then runs any accepted request through the
  // predictor (a draw never strobes in its own accept cycle, so order is safe).
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_words.size() == 0) begin
          error_count++;
          if (error_count <= ReportLimit)
            $display("[%0t] unexpected word %h with nothing pending", $realtime,
                     random_word_o);
        end else begin
          want = expected_words.pop_front();
          if (random_word_o !== want) begin
            error_count++;
            if (error_count <= ReportLimit)
              $display("[%0t] random_word mismatch: expected %h, got %h", $realtime,
                       want, random_word_o);
          end
        end
      end
      if (start && !busy) begin
        if (req_type_i == ReqReseed) fill_from_seed(seed_value_i);
        else expected_words.push_back(next_draw_word());
      end
      item_taken <= start && !busy;
    end else begin
      item_taken <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_request(input logic req, input logic [63:0] seed);
    gen_request_t r;
    r.drain = 1'b0;
    r.req   = req;
    r.seed  = seed;
    requests_pending.push_back(r);
  endtask

  task automatic queue_drain();
    gen_request_t r;
    r.drain = 1'b1;
    r.req   = ReqDraw;
    r.seed  = '0;
    requests_pending.push_back(r);
  endtask

  function automatic logic [63:0] random_seed();
    logic [63:0] s;
    case ($urandom_range(0, 7))
      0:       s = '0;
      1:       s = '1;
      2:       s = mt64_pkg::DefaultSeed;
      default: s = {$urandom(), $urandom()};
    endcase
    return s;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned run_len;
    int unsigned reseeds;

    fill_from_seed(mt64_pkg::DefaultSeed);   // store after the power-up pass

    // Directed: first draw right out of reset (exhausted index, twist first),
    // draws carrying junk seeds, extreme and single-bit seeds, reseed back to
    // the default seed, and one full drain.
    queue_request(ReqDraw, '1);
    queue_request(ReqDraw, {$urandom(), $urandom()});
    queue_request(ReqReseed, 64'h0);
    queue_request(ReqDraw, '0);
    queue_request(ReqDraw, '1);
    queue_request(ReqReseed, '1);
    queue_request(ReqDraw, 64'h0);
    queue_request(ReqReseed, 64'h8000_0000_0000_0000);
    queue_request(ReqDraw, 64'h0);
    queue_request(ReqReseed, 64'h1);
    queue_request(ReqDraw, 64'h0);
    queue_drain();
    queue_request(ReqReseed, mt64_pkg::DefaultSeed);
    queue_request(ReqDraw, 64'h0);
    queue_request(ReqDraw, 64'h0);
    queue_request(ReqDraw, 64'h0);
    queue_request(ReqReseed, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_request(ReqDraw, 64'h5555_5555_5555_5555);
    queue_request(ReqReseed, 64'h5555_5555_5555_5555);
    queue_request(ReqDraw, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_request(ReqReseed, 64'h0);   // back-to-back reseeds
    queue_request(ReqReseed, 64'h7FFF_FFFF_FFFF_FFFE);
    queue_request(ReqDraw, 64'h0);

    // Random: runs of draws, each often preceded by a reseed. Some runs are
    // long enough to cross the 312-word boundary up to three times, some stop at
    // exactly 312, some are empty so reseeds pile up.
    sent    = 0;
    reseeds = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(0, 1) == 0 && reseeds < MaxReseeds) begin
        queue_request(ReqReseed, random_seed());
        reseeds++;
        sent++;
      end
      case ($urandom_range(0, 9))
        0:       run_len = $urandom_range(300, 650);
        1:       run_len = WordCount;
        2:       run_len = 0;
        default: run_len = $urandom_range(1, 40);
      endcase
      if (run_len > RandomItems - sent) run_len = RandomItems - sent;
      repeat (run_len) queue_request(ReqDraw, {$urandom(), $urandom()});
      sent += run_len;
      if ($urandom_range(0, 5) == 0) queue_drain();
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Everything sent, then every draw answered, then a short tail for strays.
    while (requests_pending.size() > 0 || start || drain_hold) @(posedge clk_i);
    while (expected_words.size() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (error_count == 0 && expected_words.size() == 0) begin
      $display("mt19937_64_generator verification clean");
    end else begin
      $display("mt19937_64_generator verification failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run (power-up pass plus every
  // reseed, each a full pass of the seed recurrence).
  initial begin
    #8_000_000;
    $display("mt19937_64_generator verification failed");
    $finish;
  end

endmodule
